### hw/rtl/ordered_item_list_core_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef ORDERED_ITEM_LIST_CORE_ASSERT_SVH
`define ORDERED_ITEM_LIST_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define OIL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define OIL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/oil_pkg.sv
package oil_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  typedef enum logic [2:0] {
    CMD_APPEND  = 3'd0,
    CMD_PREPEND = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_FIND    = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD       = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] item_value;
    logic [3:0]  position;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  found_position;
    logic        removed_valid;
    logic [31:0] removed_item;
    logic [4:0]  item_count;
    logic        last;
  } result_t;

  // Micro-operations issued by the controller to the datapath
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_INIT_TOP,
    OP_RD_BELOW,
    OP_WR_UP,
    OP_WR_FRONT,
    OP_RD_POS,
    OP_TAKE,
    OP_RD_ABOVE,
    OP_WR_DN,
    OP_RM_DONE,
    OP_STEP_DOWN,
    OP_RD_TOP,
    OP_CLR_POP,
    OP_EMIT_FULL,
    OP_EMIT_BAD,
    OP_EMIT_NOTFOUND,
    OP_EMIT_FOUND,
    OP_EMIT_OK
  } dp_op_e;

  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic pos_bad;
    logic idx_zero;
    logic above_end;
    logic one_left;
    logic match;
  } dp_stat_t;

endpackage

### hw/rtl/ordered_item_list_core.sv
// Channel    Signals                  Handshake
// ---------  -----------------------  ---------------------------------------
// request    start, busy, req_i       taken at a clock edge with start & !busy
// result     res_valid_o, res_o       one-cycle strobe, cannot be held off
//
// A taken request first passes through a decode state. Append, errors,
// full and a clear of an empty list give their result from decode. Prepend,
// remove and find move one entry at a time through the entry memory, a read
// step and then a write or compare step per entry; clear gives one result per
// entry, popped from the top. Reset empties the list at once; entry contents
// are not cleared. busy stays high until the cycle of the final result.
`include "ordered_item_list_core_assert.svh"

module ordered_item_list_core #(
  parameter int unsigned DEPTH      = oil_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = oil_pkg::VALUE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  oil_pkg::request_t req_i,
  output logic             res_valid_o,
  output oil_pkg::result_t res_o
);
  import oil_pkg::*;

  dp_op_e   op;
  dp_stat_t stat;

  oil_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .op_o    (op),
    .busy_o  (busy)
  );

  oil_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .op_i        (op),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  `OIL_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `OIL_ASSERT_IMP(a_res_after_busy, clk_i, rst_ni, res_valid_o, $past(busy))
  `OIL_ASSERT_IMP(a_more_follows, clk_i, rst_ni, res_valid_o && !res_o.last, busy)
  `OIL_ASSERT_IMP(a_removed_ok, clk_i, rst_ni, res_valid_o && res_o.removed_valid, res_o.status == ST_OK)
  `OIL_ASSERT_IMP(a_count_bound, clk_i, rst_ni, res_valid_o, int'(res_o.item_count) <= DEPTH)

endmodule

### hw/rtl/oil_datapath.sv
module oil_datapath #(
  parameter int unsigned DEPTH      = oil_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = oil_pkg::VALUE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oil_pkg::request_t req_i,
  input  oil_pkg::dp_op_e   op_i,
  output oil_pkg::dp_stat_t stat_o,
  output oil_pkg::result_t  res_o,
  output logic              res_valid_o
);
  import oil_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = (CW > 4) ? CW : 4;

  logic [VALUE_BITS-1:0] mem_q [DEPTH];

  cmd_e                  cmd_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [3:0]            pos_q;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [VALUE_BITS-1:0] rd_q;
  logic [VALUE_BITS-1:0] taken_q, taken_d;
  result_t               res_q, res_d;
  logic                  res_valid_q, res_valid_d;

  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  logic [CW-1:0]         idx_m1, idx_p1, cnt_m1, cnt_p1;
  logic [PW-1:0]         pos_ext, cnt_ext;

  status_e               st;
  logic [CW-1:0]         fpos;
  logic                  rmv, lst;
  logic [VALUE_BITS-1:0] rmi;
  logic [7:0]            cnt_w, fpos_w;
  logic [63:0]           rmi_w;

  assign idx_m1  = idx_q - 1'b1;
  assign idx_p1  = idx_q + 1'b1;
  assign cnt_m1  = count_q - 1'b1;
  assign cnt_p1  = count_q + 1'b1;
  assign pos_ext = PW'(pos_q);
  assign cnt_ext = PW'(count_q);

  always_comb begin
    stat_o.cmd       = cmd_q;
    stat_o.full      = (count_q == CW'(DEPTH));
    stat_o.empty     = (count_q == '0);
    stat_o.pos_bad   = (pos_ext >= cnt_ext);
    stat_o.idx_zero  = (idx_q == '0);
    stat_o.above_end = (idx_p1 >= count_q);
    stat_o.one_left  = (count_q == CW'(1));
    stat_o.match     = (rd_q == val_q);
  end

  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    taken_d     = taken_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = val_q;
    res_valid_d = 1'b0;
    st          = ST_OK;
    fpos        = '0;
    rmv         = 1'b0;
    rmi         = '0;
    lst         = 1'b1;
    case (op_i)
      OP_APPEND: begin
        wr_en       = 1'b1;
        wr_addr     = count_q[AW-1:0];
        count_d     = cnt_p1;
        res_valid_d = 1'b1;
      end
      OP_INIT_TOP: idx_d = count_q;
      OP_RD_BELOW: begin
        rd_en   = 1'b1;
        rd_addr = idx_m1[AW-1:0];
      end
      OP_WR_UP: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[AW-1:0];
        wr_data = rd_q;
        idx_d   = idx_m1;
      end
      OP_WR_FRONT: begin
        wr_en       = 1'b1;
        wr_addr     = '0;
        count_d     = cnt_p1;
        res_valid_d = 1'b1;
      end
      OP_RD_POS: begin
        rd_en   = 1'b1;
        rd_addr = pos_ext[AW-1:0];
        idx_d   = pos_ext[CW-1:0];
      end
      OP_TAKE: taken_d = rd_q;
      OP_RD_ABOVE: begin
        rd_en   = 1'b1;
        rd_addr = idx_p1[AW-1:0];
      end
      OP_WR_DN: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[AW-1:0];
        wr_data = rd_q;
        idx_d   = idx_p1;
      end
      OP_RM_DONE: begin
        count_d     = cnt_m1;
        rmv         = 1'b1;
        rmi         = taken_q;
        res_valid_d = 1'b1;
      end
      OP_STEP_DOWN: idx_d = idx_m1;
      OP_RD_TOP: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[AW-1:0];
      end
      OP_CLR_POP: begin
        // top entry was read the cycle before
        count_d     = cnt_m1;
        rmv         = 1'b1;
        rmi         = rd_q;
        lst         = (cnt_m1 == '0);
        res_valid_d = 1'b1;
      end
      OP_EMIT_FULL: begin
        st          = ST_FULL;
        res_valid_d = 1'b1;
      end
      OP_EMIT_BAD: begin
        st          = ST_BAD;
        res_valid_d = 1'b1;
      end
      OP_EMIT_NOTFOUND: begin
        st          = ST_NOT_FOUND;
        res_valid_d = 1'b1;
      end
      OP_EMIT_FOUND: begin
        fpos        = idx_m1;
        res_valid_d = 1'b1;
      end
      OP_EMIT_OK: res_valid_d = 1'b1;
      default: ;
    endcase

    cnt_w  = 8'(count_d);
    fpos_w = 8'(fpos);
    rmi_w  = 64'(rmi);
    res_d.status         = st;
    res_d.found_position = fpos_w[3:0];
    res_d.removed_valid  = rmv;
    res_d.removed_item   = rmi_w[31:0];
    res_d.item_count     = cnt_w[4:0];
    res_d.last           = lst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD) begin
      cmd_q <= req_i.cmd;
      val_q <= VALUE_BITS'(req_i.item_value);
      pos_q <= req_i.position;
    end
    taken_q <= taken_d;
    if (res_valid_d) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

### hw/rtl/oil_ctrl.sv
module oil_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  oil_pkg::dp_stat_t stat_i,
  output oil_pkg::dp_op_e   op_o,
  output logic              busy_o
);
  import oil_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PRE_CHK,
    S_PRE_WR,
    S_RM_TAKE,
    S_RM_CHK,
    S_RM_WR,
    S_FIND_CHK,
    S_FIND_CMP,
    S_CLR_RD,
    S_CLR_POP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_o    = OP_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (stat_i.cmd)
          CMD_APPEND: op_o = stat_i.full ? OP_EMIT_FULL : OP_APPEND;
          CMD_PREPEND: begin
            if (stat_i.full) begin
              op_o = OP_EMIT_FULL;
            end else begin
              op_o    = OP_INIT_TOP;
              state_d = S_PRE_CHK;
            end
          end
          CMD_REMOVE: begin
            if (stat_i.pos_bad) begin
              op_o = OP_EMIT_BAD;
            end else begin
              op_o    = OP_RD_POS;
              state_d = S_RM_TAKE;
            end
          end
          CMD_FIND: begin
            op_o    = OP_INIT_TOP;
            state_d = S_FIND_CHK;
          end
          CMD_CLEAR: begin
            if (stat_i.empty) begin
              op_o = OP_EMIT_OK;
            end else begin
              op_o    = OP_RD_TOP;
              state_d = S_CLR_POP;
            end
          end
          default: op_o = OP_EMIT_BAD;
        endcase
      end
      // shift up from the top, then drop the new value into slot 0
      S_PRE_CHK: begin
        if (stat_i.idx_zero) begin
          op_o    = OP_WR_FRONT;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_RD_BELOW;
          state_d = S_PRE_WR;
        end
      end
      S_PRE_WR: begin
        op_o    = OP_WR_UP;
        state_d = S_PRE_CHK;
      end
      S_RM_TAKE: begin
        op_o    = OP_TAKE;
        state_d = S_RM_CHK;
      end
      S_RM_CHK: begin
        if (stat_i.above_end) begin
          op_o    = OP_RM_DONE;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_RD_ABOVE;
          state_d = S_RM_WR;
        end
      end
      S_RM_WR: begin
        op_o    = OP_WR_DN;
        state_d = S_RM_CHK;
      end
      // search from the top down so the highest match wins
      S_FIND_CHK: begin
        if (stat_i.idx_zero) begin
          op_o    = OP_EMIT_NOTFOUND;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_RD_BELOW;
          state_d = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (stat_i.match) begin
          op_o    = OP_EMIT_FOUND;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_STEP_DOWN;
          state_d = S_FIND_CHK;
        end
      end
      S_CLR_RD: begin
        op_o    = OP_RD_TOP;
        state_d = S_CLR_POP;
      end
      S_CLR_POP: begin
        op_o    = OP_CLR_POP;
        state_d = stat_i.one_left ? S_IDLE : S_CLR_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### tb/ordered_item_list_checker.sv
`timescale 1ns / 100ps
module ordered_item_list_checker
  import oil_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  request_t    req_i,
  input  logic        res_valid_i,
  input  result_t     res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned requests_o,
  output int unsigned results_o,
  output int unsigned full_hits_o
);

  // shadow copy of the list, index 0 at the front
  logic [31:0] list_entries_q[$];
  result_t     expected_results_q[$];

  initial begin
    fail_count_o = 0;
    requests_o   = 0;
    results_o    = 0;
    full_hits_o  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic predict_list_op(input request_t req);
    result_t exp;
    int      idx;
    exp      = '0;
    exp.last = 1'b1;
    case (req.cmd)
      CMD_APPEND, CMD_PREPEND: begin
        if (list_entries_q.size() >= DEPTH) begin
          exp.status = ST_FULL;
          full_hits_o++;
        end else if (req.cmd == CMD_APPEND) begin
          list_entries_q.push_back(req.item_value);
        end else begin
          list_entries_q.push_front(req.item_value);
        end
      end
      CMD_REMOVE: begin
        if (req.position >= list_entries_q.size()) begin
          exp.status = ST_BAD;
        end else begin
          exp.removed_valid = 1'b1;
          exp.removed_item  = list_entries_q[req.position];
          list_entries_q.delete(req.position);
        end
      end
      CMD_FIND: begin
        exp.status = ST_NOT_FOUND;
        for (idx = list_entries_q.size() - 1; idx >= 0; idx--) begin
          if (list_entries_q[idx] == req.item_value) begin
            exp.status         = ST_OK;
            exp.found_position = 4'(idx);
            break;
          end
        end
      end
      CMD_CLEAR: begin
        // one result per entry, popped from the back
        while (list_entries_q.size() > 0) begin
          exp.removed_valid = 1'b1;
          exp.removed_item  = list_entries_q.pop_back();
          exp.item_count    = 5'(list_entries_q.size());
          exp.last          = (list_entries_q.size() == 0);
          expected_results_q.push_back(exp);
        end
      end
      default: begin
        exp.status = ST_BAD;
      end
    endcase
    if (!(req.cmd == CMD_CLEAR && exp.removed_valid)) begin
      exp.item_count = 5'(list_entries_q.size());
      expected_results_q.push_back(exp);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t exp;
    if (expected_results_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing outstanding, status %0d", got.status));
      return;
    end
    exp = expected_results_q.pop_front();
    if (got.status !== exp.status)
      report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
    if (got.found_position !== exp.found_position)
      report_mismatch($sformatf("found_position %0d, expected %0d",
                                got.found_position, exp.found_position));
    if (got.removed_valid !== exp.removed_valid)
      report_mismatch($sformatf("removed_valid %0b, expected %0b",
                                got.removed_valid, exp.removed_valid));
    if (got.removed_item !== exp.removed_item)
      report_mismatch($sformatf("removed_item %08h, expected %08h",
                                got.removed_item, exp.removed_item));
    if (got.item_count !== exp.item_count)
      report_mismatch($sformatf("item_count %0d, expected %0d", got.item_count, exp.item_count));
    if (got.last !== exp.last)
      report_mismatch($sformatf("last %0b, expected %0b", got.last, exp.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_entries_q.delete();
      expected_results_q.delete();
      pending_o <= 0;
    end else begin
      // check before predicting: a new request may be taken on the final result
      if (res_valid_i === 1'b1) begin
        results_o++;
        check_result(res_i);
      end else if (res_valid_i !== 1'b0) begin
        report_mismatch("result strobe unknown");
      end
      if (start_i && busy_i === 1'b0) begin
        requests_o++;
        predict_list_op(req_i);
      end
      pending_o <= expected_results_q.size();
    end
  end

endmodule

### tb/tb_ordered_item_list_core.sv
`timescale 1ns / 100ps
module tb_ordered_item_list_core;
  import oil_pkg::*;

  localparam int unsigned DEPTH         = DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS  = 72;
  localparam int unsigned TAIL_CYCLES   = 2 * DEPTH + 8;
  localparam int unsigned CMD_CODE_MAX  = 7;
  localparam int unsigned POOL_SIZE     = 8;
  localparam longint unsigned RUN_LIMIT = 2_000_000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  request_t request;
  logic     res_valid;
  result_t  result;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned requests_seen;
  int unsigned results_seen;
  int unsigned full_hits;

  int unsigned burst_left;
  int unsigned directed_count;
  logic [31:0] value_pool [POOL_SIZE];

  ordered_item_list_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (request),
    .res_valid_o(res_valid),
    .res_o      (result)
  );

  ordered_item_list_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (request),
    .res_valid_i (res_valid),
    .res_i       (result),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .requests_o  (requests_seen),
    .results_o   (results_seen),
    .full_hits_o (full_hits)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // bursts of back-to-back requests, separated by idle gaps carrying junk
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        start   <= 1'b0;
        request <= '{cmd: cmd_e'(3'($urandom)), item_value: $urandom,
                     position: 4'($urandom)};
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  task automatic issue(input cmd_e cmd, input logic [31:0] value, input logic [3:0] pos);
    pace_sender();
    @(negedge clk);
    start   <= 1'b1;
    request <= '{cmd: cmd, item_value: value, position: pos};
    do @(posedge clk); while (busy !== 1'b0);
    if (cmd == CMD_APPEND || cmd == CMD_PREPEND)
      value_pool[$urandom_range(0, POOL_SIZE - 1)] = value;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned round_len;
    int unsigned roll;
    int          k;
    bit          grow;
    bit          paused;
    cmd_e        cmd;
    cmd_e        unknown_cmd;
    logic [3:0]  pos;

    start      = 1'b0;
    request    = '0;
    rst_n      = 1'b0;
    burst_left = 0;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list corner cases
    issue(CMD_REMOVE, '0, 4'd0);
    issue(CMD_CLEAR, '0, '0);
    issue(CMD_FIND, '1, '0);
    // fill to capacity, both ends, with a duplicate of zero
    issue(CMD_APPEND, '0, '1);
    issue(CMD_APPEND, '1, '0);
    for (k = 2; k < DEPTH; k++)
      issue(k[0] ? CMD_PREPEND : CMD_APPEND, (k == 7) ? 32'h0 : $urandom, 4'($urandom));
    issue(CMD_APPEND, $urandom, '0);
    issue(CMD_PREPEND, $urandom, '1);
    issue(CMD_FIND, '0, '0);
    issue(CMD_FIND, 32'h1357_9bdf, '0);
    issue(CMD_REMOVE, $urandom, 4'(DEPTH - 1));
    issue(CMD_REMOVE, $urandom, 4'd0);
    issue(CMD_REMOVE, $urandom, 4'(DEPTH - 1));
    issue(cmd_e'(3'(CMD_CODE_MAX)), $urandom, '0);
    issue(CMD_CLEAR, $urandom, '0);
    directed_count = requests_seen;

    // rounds that lean towards filling or draining the list
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      grow      = $urandom_range(0, 1);
      round_len = $urandom_range(8, 20);
      for (k = 0; k < round_len && sent < RANDOM_ITEMS; k++) begin
        roll        = $urandom_range(0, 99);
        unknown_cmd = cmd_e'(3'($urandom_range(int'(CMD_CLEAR) + 1, CMD_CODE_MAX)));
        if (grow)
          cmd = roll < 40 ? CMD_APPEND : roll < 70 ? CMD_PREPEND : roll < 82 ? CMD_REMOVE :
                roll < 95 ? CMD_FIND : roll < 97 ? CMD_CLEAR : unknown_cmd;
        else
          cmd = roll < 15 ? CMD_APPEND : roll < 25 ? CMD_PREPEND : roll < 65 ? CMD_REMOVE :
                roll < 85 ? CMD_FIND : roll < 93 ? CMD_CLEAR : unknown_cmd;
        pos = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        issue(cmd, pick_value(), pos);
        sent++;
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_all_results();
        paused = 1'b1;
      end
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d requests (%0d directed) and %0d results",
             requests_seen, directed_count, results_seen);
    $display("list reported full %0d times, %0d mismatches", full_hits, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
